/* rtl/core/fraction_arith_reduce_top_macros.svh */
// assertion helpers shared by the fraction block modules
// each expects i_clk and i_rst_n in the enclosing module
`ifndef FRACTION_ARITH_REDUCE_TOP_MACROS_SVH
`define FRACTION_ARITH_REDUCE_TOP_MACROS_SVH

// same-cycle implication
`define FAR_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FAR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/far_pkg.sv */
`default_nettype none

package far_pkg;

    // internal result width
    localparam int WIDE  = 64;
    localparam int CNT_W = $clog2(WIDE);

    // operation codes
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_SUB      = 3'd1;
    localparam logic [2:0] OP_MUL      = 3'd2;
    localparam logic [2:0] OP_DIV      = 3'd3;
    localparam logic [2:0] OP_SIMPLIFY = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [WIDE-1:0] TOP_BIT = {1'b1, {(WIDE-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_SCREEN,
        S_GCD,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MUL_P0,
        MUL_P1,
        MUL_P2
    } t_mul_sel;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        t_mul_sel   mul_sel;
        logic       cap_t0;
        logic       cap_t1;
        logic       sum_en;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        logic       out_zero;
        logic [1:0] out_code;
    } t_dp_cmd;

    typedef struct packed {
        logic       early;
        logic [1:0] early_code;
        logic       ovf;
        logic       num_zero;
        logic       gcd_done;
        logic       div_last;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/core/far_ctrl.sv */
`default_nettype none
`include "fraction_arith_reduce_top_macros.svh"

module far_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  wire               i_ready,
    output far_pkg::t_dp_cmd  o_cmd,
    input  far_pkg::t_dp_sts  i_sts
);
    import far_pkg::*;

    t_state     r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       r_zero, n_zero;
    logic [1:0] r_code, n_code;
    logic       w_out_free;

    // output register can take a new item
    assign w_out_free = !r_out_valid || i_ready;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // next state and result kind
    always_comb begin
        n_state = r_state;
        n_zero  = r_zero;
        n_code  = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.early) begin
                    n_zero  = 1'b1;
                    n_code  = i_sts.early_code;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUM;
            S_SUM:   n_state = S_SCREEN;
            S_SCREEN: begin
                if (i_sts.ovf) begin
                    n_zero  = 1'b1;
                    n_code  = ST_OVERFLOW;
                    n_state = S_EMIT;
                end else if (i_sts.num_zero) begin
                    n_zero  = 1'b1;
                    n_code  = ST_OK;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_zero  = 1'b0;
                    n_code  = ST_OK;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_P0;
        o_cmd.out_zero = r_zero;
        o_cmd.out_code = r_code;
        unique case (r_state)
            S_IDLE:   o_cmd.load = i_valid;
            S_CHECK:  o_cmd.load = 1'b0;
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P0;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P1;
                o_cmd.cap_t0  = 1'b1;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P2;
                o_cmd.cap_t1  = 1'b1;
            end
            S_SUM:    o_cmd.sum_en = 1'b1;
            S_SCREEN: o_cmd.gcd_init = !i_sts.ovf && !i_sts.num_zero;
            S_GCD: begin
                o_cmd.gcd_step = !i_sts.gcd_done;
                o_cmd.div_init = i_sts.gcd_done;
            end
            S_DIV:    o_cmd.div_step = 1'b1;
            S_EMIT:   o_cmd.out_load = w_out_free;
            default:  o_cmd.load = 1'b0;
        endcase
    end

    // result valid flag
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_zero      <= 1'b0;
            r_code      <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_zero      <= n_zero;
            r_code      <= n_code;
        end
    end

    `FAR_ASSERT_NXT(a_emit_done, (r_state == S_EMIT) && w_out_free, (r_state == S_IDLE) && r_out_valid, "emitted item not presented")
    `FAR_ASSERT_NXT(a_accept_check, i_valid && o_ready, r_state == S_CHECK, "accepted item not checked")
    `FAR_ASSERT_NXT(a_div_to_emit, (r_state == S_DIV) && i_sts.div_last, (r_state == S_EMIT) && !r_zero, "division end lost")

endmodule

`default_nettype wire

/* rtl/core/far_datapath.sv */
`default_nettype none
`include "fraction_arith_reduce_top_macros.svh"

module far_datapath #(
    parameter int OPERAND_BITS = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  far_pkg::t_dp_cmd  i_cmd,
    output far_pkg::t_dp_sts  o_sts,
    input  wire [2:0]         i_operation,
    input  wire [31:0]        i_first_num,
    input  wire [31:0]        i_first_den,
    input  wire [31:0]        i_second_num,
    input  wire [31:0]        i_second_den,
    output logic [63:0]       o_raw_num,
    output logic [63:0]       o_raw_den,
    output logic [63:0]       o_reduced_num,
    output logic [62:0]       o_reduced_den,
    output logic [1:0]        o_status
);
    import far_pkg::*;

    localparam int PROD_W = 2 * OPERAND_BITS;

    // captured operands
    logic [2:0]                     r_op;
    logic signed [OPERAND_BITS-1:0] r_a, r_b, r_c, r_d;

    // shared multiplier
    logic signed [OPERAND_BITS-1:0] w_mx, w_my;
    logic signed [PROD_W-1:0]       w_mx_ext, w_my_ext;
    logic signed [PROD_W-1:0]       r_prod;
    logic [WIDE-1:0]                r_t0, r_t1;

    // unreduced fraction
    logic [WIDE:0]                  w_sum;
    logic [WIDE-1:0]                r_num, r_den;
    logic                           r_ovf;
    logic [WIDE-1:0]                w_un, w_ud;

    // binary gcd
    logic [WIDE-1:0]                r_x, r_y, n_x, n_y;
    logic [CNT_W-1:0]               r_k, n_k;
    logic [WIDE-1:0]                w_g;

    // restoring division, two lanes sharing the divisor
    logic [WIDE-1:0]                r_g;
    logic [WIDE-1:0]                r_qn, r_qd, r_rn, r_rd;
    logic [CNT_W-1:0]               r_div_cnt;
    logic [WIDE:0]                  w_rn_sh, w_rd_sh, w_rn_sub, w_rd_sub;
    logic                           w_ge_n, w_ge_d;

    // final result
    logic                           w_neg, w_ovf2;

    logic [63:0]                    r_o_raw_num, r_o_raw_den, r_o_rnum;
    logic [62:0]                    r_o_rden;
    logic [1:0]                     r_o_status;

    // early screening of the captured item
    logic w_bad_op, w_zero_den, w_div_zero;
    assign w_bad_op   = (r_op > OP_SIMPLIFY);
    assign w_zero_den = (r_b == '0) || ((r_op != OP_SIMPLIFY) && (r_d == '0));
    assign w_div_zero = (r_op == OP_DIV) && (r_c == '0);

    always_comb begin
        o_sts.early = w_bad_op || w_zero_den || w_div_zero;
        priority if (w_bad_op) begin
            o_sts.early_code = ST_OK;
        end else if (w_zero_den) begin
            o_sts.early_code = ST_ZERO_DEN;
        end else begin
            o_sts.early_code = ST_DIV_ZERO;
        end
        o_sts.ovf      = r_ovf;
        o_sts.num_zero = (r_num == '0);
        o_sts.gcd_done = (r_x == '0) || (r_y == '0);
        o_sts.div_last = &r_div_cnt;
    end

    // multiplier operand selection
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_P0: begin
                w_mx = r_a;
                w_my = (r_op == OP_MUL) ? r_c : r_d;
            end
            MUL_P1: begin
                w_mx = r_c;
                w_my = r_b;
            end
            MUL_P2: begin
                w_mx = r_b;
                w_my = (r_op == OP_DIV) ? r_c : r_d;
            end
            default: begin
                w_mx = r_a;
                w_my = r_d;
            end
        endcase
        w_mx_ext = PROD_W'(w_mx);
        w_my_ext = PROD_W'(w_my);
    end

    // cross sum with one guard bit
    always_comb begin
        if (r_op == OP_SUB) begin
            w_sum = {r_t0[WIDE-1], r_t0} - {r_t1[WIDE-1], r_t1};
        end else begin
            w_sum = {r_t0[WIDE-1], r_t0} + {r_t1[WIDE-1], r_t1};
        end
    end

    assign w_un = r_num[WIDE-1] ? (WIDE'(0) - r_num) : r_num;
    assign w_ud = r_den[WIDE-1] ? (WIDE'(0) - r_den) : r_den;

    // one binary gcd step
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_k = r_k;
        priority if (!r_x[0] && !r_y[0]) begin
            n_x = r_x >> 1;
            n_y = r_y >> 1;
            n_k = r_k + CNT_W'(1);
        end else if (!r_x[0]) begin
            n_x = r_x >> 1;
        end else if (!r_y[0]) begin
            n_y = r_y >> 1;
        end else if (r_x >= r_y) begin
            n_x = (r_x - r_y) >> 1;
        end else begin
            n_y = (r_y - r_x) >> 1;
        end
    end

    assign w_g = (r_x | r_y) << r_k;

    // division lanes
    assign w_rn_sh  = {r_rn, r_qn[WIDE-1]};
    assign w_rd_sh  = {r_rd, r_qd[WIDE-1]};
    assign w_rn_sub = w_rn_sh - {1'b0, r_g};
    assign w_rd_sub = w_rd_sh - {1'b0, r_g};
    assign w_ge_n   = (w_rn_sh >= {1'b0, r_g});
    assign w_ge_d   = (w_rd_sh >= {1'b0, r_g});

    // sign and range of the reduced form
    assign w_neg  = r_num[WIDE-1] ^ r_den[WIDE-1];
    assign w_ovf2 = r_qd[WIDE-1] || (w_neg ? (r_qn > TOP_BIT) : r_qn[WIDE-1]);

    // capture, multiply and sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_a  <= i_first_num[OPERAND_BITS-1:0];
            r_b  <= i_first_den[OPERAND_BITS-1:0];
            r_c  <= i_second_num[OPERAND_BITS-1:0];
            r_d  <= i_second_den[OPERAND_BITS-1:0];
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mx_ext * w_my_ext;
        end
        if (i_cmd.cap_t0) begin
            r_t0 <= WIDE'(r_prod);
        end
        if (i_cmd.cap_t1) begin
            r_t1 <= WIDE'(r_prod);
        end
        if (i_cmd.sum_en) begin
            r_ovf <= 1'b0;
            unique case (r_op)
                OP_ADD, OP_SUB: begin
                    r_num <= w_sum[WIDE-1:0];
                    r_ovf <= w_sum[WIDE] ^ w_sum[WIDE-1];
                end
                OP_MUL, OP_DIV: r_num <= r_t0;
                default:        r_num <= WIDE'(r_a);
            endcase
            r_den <= (r_op == OP_SIMPLIFY) ? WIDE'(r_b) : WIDE'(r_prod);
        end
    end

    // gcd and division sequencing
    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_x <= w_un;
            r_y <= w_ud;
            r_k <= '0;
        end else if (i_cmd.gcd_step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_k <= n_k;
        end
        if (i_cmd.div_init) begin
            r_g       <= w_g;
            r_qn      <= w_un;
            r_qd      <= w_ud;
            r_rn      <= '0;
            r_rd      <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rn      <= w_ge_n ? w_rn_sub[WIDE-1:0] : w_rn_sh[WIDE-1:0];
            r_rd      <= w_ge_d ? w_rd_sub[WIDE-1:0] : w_rd_sh[WIDE-1:0];
            r_qn      <= {r_qn[WIDE-2:0], w_ge_n};
            r_qd      <= {r_qd[WIDE-2:0], w_ge_d};
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero || w_ovf2) begin
                r_o_raw_num <= '0;
                r_o_raw_den <= '0;
                r_o_rnum    <= '0;
                r_o_rden    <= '0;
                r_o_status  <= i_cmd.out_zero ? i_cmd.out_code : ST_OVERFLOW;
            end else begin
                r_o_raw_num <= r_num;
                r_o_raw_den <= r_den;
                r_o_rnum    <= w_neg ? (WIDE'(0) - r_qn) : r_qn;
                r_o_rden    <= r_qd[WIDE-2:0];
                r_o_status  <= ST_OK;
            end
        end
    end

    assign o_raw_num     = r_o_raw_num;
    assign o_raw_den     = r_o_raw_den;
    assign o_reduced_num = r_o_rnum;
    assign o_reduced_den = r_o_rden;
    assign o_status      = r_o_status;

    `FAR_ASSERT_IMM(a_gcd_live, i_cmd.gcd_step, (r_x != '0) && (r_y != '0), "gcd stepped after finish")
    `FAR_ASSERT_IMM(a_gcd_nonzero, i_cmd.div_init, w_g != '0, "zero divisor from gcd")
    `FAR_ASSERT_NXT(a_full_den, i_cmd.out_load && !i_cmd.out_zero, (r_o_status == ST_OVERFLOW) || (r_o_rden != '0), "reduced denominator zero")

endmodule

`default_nettype wire

/* rtl/core/fraction_arith_reduce_top.sv */
// fraction arithmetic with gcd reduction
// input channel i_valid / o_ready carries an operation code and two signed
// fractions; output channel o_valid / i_ready returns one item per input:
// the unreduced result fraction, the form reduced by the gcd with
// a positive denominator, and a status (ok, zero denominator, divide by a
// zero fraction, overflow)
// one item is worked at a time; o_ready is high only while the controller
// is idle. a zero denominator, divide by zero or unused operation finishes
// straight after the check state; a zero numerator or overflowing sum after
// the screen state. otherwise the item runs binary gcd steps over the
// 64-bit magnitudes, then restoring division of both terms by the gcd
// the three products go through one shared multiplier
// results sit in an output register; the next item is taken while a result
// waits, and it is held in its final step until the receiver takes the
// previous one. reset empties the output register and returns to idle
`default_nettype none

module fraction_arith_reduce_top #(
    parameter int OPERAND_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [2:0]   i_operation,
    input  wire [31:0]  i_first_num,
    input  wire [31:0]  i_first_den,
    input  wire [31:0]  i_second_num,
    input  wire [31:0]  i_second_den,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_raw_num,
    output logic [63:0] o_raw_den,
    output logic [63:0] o_reduced_num,
    output logic [62:0] o_reduced_den,
    output logic [1:0]  o_status
);
    import far_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    far_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // arithmetic
    far_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_operation   (i_operation),
        .i_first_num   (i_first_num),
        .i_first_den   (i_first_den),
        .i_second_num  (i_second_num),
        .i_second_den  (i_second_den),
        .o_raw_num     (o_raw_num),
        .o_raw_den     (o_raw_den),
        .o_reduced_num (o_reduced_num),
        .o_reduced_den (o_reduced_den),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

/* tb/far_result_checker.sv */
`default_nettype none

module far_result_checker #(
    parameter int OPERAND_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_valid,
    input  wire         i_in_ready,
    input  wire [2:0]   i_operation,
    input  wire [31:0]  i_first_num,
    input  wire [31:0]  i_first_den,
    input  wire [31:0]  i_second_num,
    input  wire [31:0]  i_second_den,
    // output channel
    input  wire         i_out_valid,
    input  wire         i_ready,
    input  wire [63:0]  i_raw_num,
    input  wire [63:0]  i_raw_den,
    input  wire [63:0]  i_reduced_num,
    input  wire [62:0]  i_reduced_den,
    input  wire [1:0]   i_status,
    // counts for the top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_item_count,
    output int          o_result_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import far_pkg::*;

    localparam logic [63:0] MAG63 = TOP_BIT - 64'd1;

    typedef struct packed {
        logic [63:0] raw_num;
        logic [63:0] raw_den;
        logic [63:0] reduced_num;
        logic [62:0] reduced_den;
        logic [1:0]  status;
    } t_fraction_result;

    t_fraction_result fraction_q[$];
    t_fraction_result oldest;

    int fail_count   = 0;
    int item_count   = 0;
    int result_count = 0;

    assign o_fail_count   = fail_count;
    assign o_item_count   = item_count;
    assign o_result_count = result_count;

    // low operand bits read as two's complement at operand width
    function automatic logic signed [63:0] operand_value(input logic [31:0] raw);
        logic [63:0] v;
        v = {32'd0, raw} & ((64'd1 << OPERAND_BITS) - 64'd1);
        if (v[OPERAND_BITS-1]) begin
            v = v - (64'd1 << OPERAND_BITS);
        end
        return $signed(v);
    endfunction

    // cross-multiplied fraction, then reduction by the gcd
    function automatic t_fraction_result reduce_fraction(
        input logic [2:0]  op,
        input logic [31:0] fn,
        input logic [31:0] fd,
        input logic [31:0] sn,
        input logic [31:0] sd
    );
        t_fraction_result   r;
        logic signed [63:0] a, b, c, d, n, m, ad, cb;
        logic signed [64:0] wide_sum;
        logic [63:0]        un, ud, x, y, t, qn, qd;
        logic               neg, ok;
        r  = '0;
        ok = 1'b1;
        a  = operand_value(fn);
        b  = operand_value(fd);
        c  = operand_value(sn);
        d  = operand_value(sd);
        ad = a * d;
        cb = c * b;
        n  = '0;
        m  = '0;
        // unused codes give an all-zero ok result
        if (op > OP_SIMPLIFY) begin
            return r;
        end
        if (b == 0 || (op != OP_SIMPLIFY && d == 0)) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (op == OP_DIV && c == 0) begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (op)
            OP_ADD: begin
                wide_sum = {ad[63], ad} + {cb[63], cb};
                ok = (wide_sum[64] == wide_sum[63]);
                n  = wide_sum[63:0];
                m  = b * d;
            end
            OP_SUB: begin
                wide_sum = {ad[63], ad} - {cb[63], cb};
                ok = (wide_sum[64] == wide_sum[63]);
                n  = wide_sum[63:0];
                m  = b * d;
            end
            OP_MUL: begin
                n = a * c;
                m = b * d;
            end
            OP_DIV: begin
                n = ad;
                m = b * c;
            end
            default: begin
                n = a;
                m = b;
            end
        endcase
        if (!ok) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        // zero numerator clears the denominator too
        if (n == 0) begin
            return r;
        end
        un = n[63] ? 64'd0 - n : n;
        ud = m[63] ? 64'd0 - m : m;
        x  = un;
        y  = ud;
        while (y != 64'd0) begin
            t = x % y;
            x = y;
            y = t;
        end
        qn  = un / x;
        qd  = ud / x;
        neg = n[63] ^ m[63];
        if (qd > MAG63 || (neg ? qn > TOP_BIT : qn > MAG63)) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.raw_num     = n;
        r.raw_den     = m;
        r.reduced_num = neg ? 64'd0 - qn : qn;
        r.reduced_den = qd[62:0];
        r.status      = ST_OK;
        return r;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      result_count, name, got, want));
        end
    endtask

    // watch both channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_ready) begin
                if (fraction_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item waiting",
                                              result_count));
                end else begin
                    oldest = fraction_q.pop_front();
                    check_field("raw_num", i_raw_num, oldest.raw_num);
                    check_field("raw_den", i_raw_den, oldest.raw_den);
                    check_field("reduced_num", i_reduced_num, oldest.reduced_num);
                    check_field("reduced_den", {1'b0, i_reduced_den},
                                {1'b0, oldest.reduced_den});
                    check_field("status", {62'd0, i_status}, {62'd0, oldest.status});
                end
                result_count++;
            end
            if (i_valid && i_in_ready) begin
                fraction_q.push_back(reduce_fraction(i_operation, i_first_num,
                                                     i_first_den, i_second_num,
                                                     i_second_den));
                item_count++;
            end
            o_pending <= fraction_q.size();
        end else begin
            o_pending <= 0;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_fraction_arith_reduce_top.sv */
`default_nettype none

module tb_fraction_arith_reduce_top;

    timeunit 1ns;
    timeprecision 1ps;

    import far_pkg::*;

    localparam int OPERAND_BITS = 32;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [2:0]  i_operation  = '0;
    logic [31:0] i_first_num  = '0;
    logic [31:0] i_first_den  = '0;
    logic [31:0] i_second_num = '0;
    logic [31:0] i_second_den = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [63:0] o_raw_num;
    logic [63:0] o_raw_den;
    logic [63:0] o_reduced_num;
    logic [62:0] o_reduced_den;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    int item_count;
    int result_count;

    // calm and hold_req are shared between sender and receiver
    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int sent_count     = 0;
    int directed_items = 0;

    fraction_arith_reduce_top #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_first_num   (i_first_num),
        .i_first_den   (i_first_den),
        .i_second_num  (i_second_num),
        .i_second_den  (i_second_den),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_raw_num     (o_raw_num),
        .o_raw_den     (o_raw_den),
        .o_reduced_num (o_reduced_num),
        .o_reduced_den (o_reduced_den),
        .o_status      (o_status)
    );

    far_result_checker #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_ready     (o_ready),
        .i_operation    (i_operation),
        .i_first_num    (i_first_num),
        .i_first_den    (i_first_den),
        .i_second_num   (i_second_num),
        .i_second_den   (i_second_den),
        .i_out_valid    (o_valid),
        .i_ready        (i_ready),
        .i_raw_num      (o_raw_num),
        .i_raw_den      (o_raw_den),
        .i_reduced_num  (o_reduced_num),
        .i_reduced_den  (o_reduced_den),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_item_count   (item_count),
        .o_result_count (result_count)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // overall time limit
    initial begin
        #80_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [2:0] op, input logic [31:0] fn,
                             input logic [31:0] fd, input logic [31:0] sn,
                             input logic [31:0] sd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_first_num  <= fn;
        i_first_den  <= fd;
        i_second_num <= sn;
        i_second_den <= sd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // sender idle until every result has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // operand mix: zero or a power of two, extremes, full random, small with shared factors, shifted
    function automatic logic [31:0] random_operand(input bit is_den);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                if (is_den && $urandom_range(0, 3) != 0) begin
                    v = 32'd1 << $urandom_range(0, 31);
                end else begin
                    v = 32'd0;
                end
            end
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'hffff_ffff;
                    default: v = 32'h0000_0001;
                endcase
            end
            2, 3, 4: v = $urandom;
            5, 6, 7: begin
                v = $urandom_range(1, 60) * $urandom_range(1, 12);
                if ($urandom_range(0, 1)) begin
                    v = 32'd0 - v;
                end
            end
            default: begin
                v = {16'd0, 16'($urandom)} << $urandom_range(0, 15);
            end
        endcase
        return v;
    endfunction

    // receiver: random stall per item, one long hold-off on request
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        logic [2:0] op;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items
        send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);            // zero numerator
        send_item(OP_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
        send_item(OP_DIV, 32'd2, 32'd3, 32'd4, 32'd5);
        send_item(OP_SIMPLIFY, 32'd6, -32'sd8, 32'd0, 32'd0);     // second ignored
        send_item(OP_SIMPLIFY, 32'd0, 32'd5, 32'd7, 32'd9);
        send_item(OP_ADD, 32'd3, 32'd0, 32'd1, 32'd2);            // zero first den
        send_item(OP_MUL, 32'd3, 32'd4, 32'd1, 32'd0);            // zero second den
        send_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);            // divide by zero fraction
        send_item(OP_DIV, 32'd3, 32'd0, 32'd0, 32'd0);            // zero den checked first
        send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);                  // sum overflow
        send_item(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff);
        send_item(OP_SUB, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_item(OP_DIV, 32'h8000_0000, 32'd1, 32'd1, 32'h8000_0000);
        send_item(OP_DIV, -32'sd7, 32'd3, -32'sd7, 32'd3);        // negative raw den
        send_item(OP_SIMPLIFY, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
        send_item(OP_SIMPLIFY, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd0);
        send_item(OP_SIMPLIFY, 32'hffff_ffff, 32'h8000_0000, 32'd0, 32'd0);
        send_item(3'd5, 32'd1, 32'd2, 32'd3, 32'd4);              // unused codes
        send_item(3'd6, 32'd1, 32'd0, 32'd3, 32'd0);
        send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        directed_items = sent_count;

        // random items with a long receiver hold, a full drain and a calm stretch
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) begin
                hold_req = 1'b1;
            end
            if (i == 700) begin
                wait_for_drain();
            end
            calm = (i >= 1100 && i < 1250);
            if ($urandom_range(0, 99) < 5) begin
                op = 3'($urandom_range(5, 7));
            end else begin
                op = 3'($urandom_range(0, 4));
            end
            send_item(op, random_operand(1'b0), random_operand(1'b1),
                      random_operand(1'b0), random_operand(1'b1));
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items (%0d directed) and %0d results over all operations,",
                 item_count, directed_items, result_count);
        $display("unused codes, zero dens, divide by zero, overflow, a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
